### sv/assert_macros.svh
// Assertion macros used by the checker of the sorted list merger.
// Each macro clocks on the rising edge and is disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: the consequent must hold in the same cycle.
`define SLM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Non-overlapping implication: the consequent must hold in the next cycle.
`define SLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### sv/slm_pkg.sv
// Package of the sorted list merger: sizes, operation codes, control structs
// and value conversion helpers. No dependencies.
`default_nettype none

package slm_pkg;

    localparam int LIST_DEPTH  = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int PORT_WIDTH  = 32;
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);

    typedef logic [VALUE_WIDTH-1:0] elem_t;
    typedef logic [CNT_W-1:0]       count_t;

    typedef enum logic [1:0] {
        OP_PUSH_FIRST  = 2'd0,
        OP_PUSH_SECOND = 2'd1,
        OP_MERGE       = 2'd2,
        OP_UNUSED      = 2'd3
    } op_t;

    typedef struct packed {
        logic push;
        logic pop;
    } list_ctrl_t;

    typedef struct packed {
        count_t count;
        logic   empty;
        logic   full;
    } list_stat_t;

    // Keep the low VALUE_WIDTH bits of an input value.
    function automatic elem_t to_elem(input logic [PORT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[VALUE_WIDTH-1:0];
    endfunction

    // Present a stored element on the 32-bit result field.
    function automatic logic [PORT_WIDTH-1:0] to_port(input elem_t v);
        logic [63:0] w;
        w = 64'(v);
        return w[PORT_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/slm_if.sv
// Handshake interfaces of the sorted list merger: command items in, merged
// result items out. Depends on slm_pkg.
`default_nettype none

interface slm_cmd_if;
    import slm_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface slm_res_if;
    import slm_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [31:0] merged_value;
    logic               last;
    logic               overflowed;

    modport source (output valid, output merged_value, output last, output overflowed,
                    input ready);
    modport sink   (input valid, input merged_value, input last, input overflowed,
                    output ready);
endinterface

`default_nettype wire

### sv/slm_cell.sv
// One storage cell of a list chain: loads a pushed element or takes its
// upper neighbor's element when the list pops. Depends on slm_pkg.
`default_nettype none

module slm_cell (
    input  wire logic          clk,
    input  wire logic          load,
    input  wire logic          shift,
    input  wire slm_pkg::elem_t load_data,
    input  wire slm_pkg::elem_t neighbor_data,
    output slm_pkg::elem_t      data
);
    import slm_pkg::*;

    elem_t data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
        else if (shift)
        begin
            data_reg <= neighbor_data;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### sv/slm_list.sv
// One list: a chain of slm_cell with its fill count. Pushes land in the cell
// at the fill count; a pop moves every cell down by one. Depends on slm_pkg.
`default_nettype none

module slm_list (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire slm_pkg::list_ctrl_t ctrl,
    input  wire slm_pkg::elem_t      push_data,
    output slm_pkg::elem_t           head,
    output slm_pkg::list_stat_t      stat
);
    import slm_pkg::*;

    elem_t  cell_data [LIST_DEPTH];
    count_t count_reg;
    count_t count_next;

    genvar i;
    generate
        for (i = 0; i < LIST_DEPTH; i++)
        begin : g_cell
            elem_t neighbor;
            if (i == LIST_DEPTH - 1)
            begin : g_top
                assign neighbor = cell_data[i];
            end
            else
            begin : g_mid
                assign neighbor = cell_data[i+1];
            end

            slm_cell u_cell (
                .clk           (clk),
                .load          (ctrl.push && (count_reg == CNT_W'(i))),
                .shift         (ctrl.pop),
                .load_data     (push_data),
                .neighbor_data (neighbor),
                .data          (cell_data[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head       = cell_data[0];
    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(LIST_DEPTH));

endmodule

`default_nettype wire

### sv/sorted_list_merger_core.sv
// Sorted list merger. A push or an unused code leaves the state idle. A merge
// first moves the state to ST_MERGE, then emits one element per cycle while the sink
// takes them; each result passes through the result valid register, and the
// command side waits until the last element has been picked from the cell chains.
// Reset clears the fill counts, the overflow flag, the state and the result
// valid; the cell contents are not reset.
`default_nettype none

module sorted_list_merger_core (
    input  wire logic clk,
    input  wire logic rst_n,
    slm_cmd_if.sink   cmd,
    slm_res_if.source result
);
    import slm_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

    state_t     state_reg;
    logic       overflow_reg;
    logic       flag_snap_reg;
    logic       res_valid_reg;
    logic [PORT_WIDTH-1:0] res_value_reg;
    logic       res_last_reg;
    logic       res_ovf_reg;

    list_ctrl_t ctrl_a, ctrl_b;
    list_stat_t stat_a, stat_b;
    elem_t      head_a, head_b;
    elem_t      push_elem;

    logic accept;
    logic op_push_a, op_push_b, op_merge;
    logic slot_free, emit, take_first, final_elem;

    assign accept    = cmd.valid && cmd.ready;
    assign op_push_a = accept && (cmd.operation == OP_PUSH_FIRST);
    assign op_push_b = accept && (cmd.operation == OP_PUSH_SECOND);
    assign op_merge  = accept && (cmd.operation == OP_MERGE);
    assign push_elem = to_elem($unsigned(cmd.value));

    assign slot_free  = !res_valid_reg || result.ready;
    assign emit       = (state_reg == ST_MERGE) && slot_free &&
                        !(stat_a.empty && stat_b.empty);
    // Ties go to the first list.
    assign take_first = stat_b.empty ||
                        (!stat_a.empty && ($signed(head_a) <= $signed(head_b)));
    assign final_elem = (stat_a.count == CNT_W'(1) && stat_b.empty) ||
                        (stat_b.count == CNT_W'(1) && stat_a.empty);

    assign ctrl_a.push = op_push_a && !stat_a.full;
    assign ctrl_b.push = op_push_b && !stat_b.full;
    assign ctrl_a.pop  = emit && take_first;
    assign ctrl_b.pop  = emit && !take_first;

    slm_list u_list_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_a),
        .push_data (push_elem),
        .head      (head_a),
        .stat      (stat_a)
    );

    slm_list u_list_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_b),
        .push_data (push_elem),
        .head      (head_b),
        .stat      (stat_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            overflow_reg  <= 1'b0;
            flag_snap_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if ((op_push_a && stat_a.full) || (op_push_b && stat_b.full))
                    begin
                        overflow_reg <= 1'b1;
                    end
                    if (op_merge)
                    begin
                        flag_snap_reg <= overflow_reg;
                        overflow_reg  <= 1'b0;
                        state_reg     <= ST_MERGE;
                    end
                end
                ST_MERGE:
                begin
                    if ((stat_a.empty && stat_b.empty) || (emit && final_elem))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (slot_free)
            begin
                res_valid_reg <= emit;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_value_reg <= to_port(take_first ? head_a : head_b);
            res_last_reg  <= final_elem;
            res_ovf_reg   <= flag_snap_reg;
        end
    end

    assign cmd.ready           = (state_reg == ST_IDLE);
    assign result.valid        = res_valid_reg;
    assign result.merged_value = $signed(res_value_reg);
    assign result.last         = res_last_reg;
    assign result.overflowed   = res_ovf_reg;

endmodule

`default_nettype wire

### sv/slm_checker.sv
// Port-level checks of sorted_list_merger_core, attached by the bind below.
// Depends on slm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module slm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cmd_valid,
    input wire logic        cmd_ready,
    input wire logic [1:0]  cmd_operation,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [31:0] res_merged_value,
    input wire logic        res_last,
    input wire logic        res_overflowed
);
    import slm_pkg::*;

    // A stalled result keeps its payload.
    `SLM_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_merged_value) && $stable(res_last))

    // A push never blocks the command side.
    `SLM_ASSERT_NEXT(a_push_idle, clk, rst_n, cmd_valid && cmd_ready && (cmd_operation == OP_PUSH_FIRST || cmd_operation == OP_PUSH_SECOND), cmd_ready)

    // While a merge still has elements to deliver, no command item is taken.
    `SLM_ASSERT_IMPL(a_merge_busy, clk, rst_n, res_valid && !res_last, !cmd_ready)

    // All results of one merge carry the same overflow mark.
    `SLM_ASSERT_NEXT(a_ovf_const, clk, rst_n, res_valid && res_ready && !res_last, !res_valid || (res_overflowed == $past(res_overflowed)))

endmodule

bind sorted_list_merger_core slm_checker u_slm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .cmd_operation    (cmd.operation),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .res_merged_value (result.merged_value),
    .res_last         (result.last),
    .res_overflowed   (result.overflowed)
);

`default_nettype wire
